[hw/rtl/assert_macros.svh]
// Assertion helpers included by palette_color_packer_unit.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that an expression is never true outside reset.
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

[hw/rtl/pcp_pkg.sv]
// ----------------------------------------------------------------------------
// pcp_pkg
// Shared types and codes of the palette color packer.
// ----------------------------------------------------------------------------
package pcp_pkg;

	// Register indexes on the configuration port
	localparam logic [1:0] REG_COLOR_LAYOUT    = 2'd0;
	localparam logic [1:0] REG_GRAYSCALE_ON    = 2'd1;
	localparam logic [1:0] REG_BIT_MIRROR      = 2'd2;
	localparam logic [1:0] REG_TRUECOLOR       = 2'd3;

	// Pixel format codes
	localparam logic [1:0] FMT_ARGB8888 = 2'd0;
	localparam logic [1:0] FMT_RGBA8888 = 2'd1;
	localparam logic [1:0] FMT_RGB565   = 2'd2;

	// Result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_RANGE    = 2'd1;
	localparam logic [1:0] ST_NOTTRUE  = 2'd2;

	typedef struct packed {
		logic [1:0] color_layout;
		logic       grayscale_on;
		logic       bit_mirror;
		logic       truecolor_visual;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  entry_index;
		logic [15:0] red_level;
		logic [15:0] green_level;
		logic [15:0] blue_level;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  entry_out;
		logic [31:0] packed_color;
		logic [1:0]  status;
	} out_item_t;

endpackage

[hw/rtl/pcp_cfg_regs.sv]
// ----------------------------------------------------------------------------
// pcp_cfg_regs
// Configuration register file: decodes writes and holds the four settings.
// ----------------------------------------------------------------------------
module pcp_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [1:0]    cfg_wdata,
	output pcp_pkg::cfg_t cfg
);

	pcp_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.color_layout     <= pcp_pkg::FMT_ARGB8888;
			cfg_q.grayscale_on     <= 1'b0;
			cfg_q.bit_mirror       <= 1'b0;
			cfg_q.truecolor_visual <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				pcp_pkg::REG_COLOR_LAYOUT: cfg_q.color_layout     <= cfg_wdata;
				pcp_pkg::REG_GRAYSCALE_ON: cfg_q.grayscale_on     <= cfg_wdata[0];
				pcp_pkg::REG_BIT_MIRROR:   cfg_q.bit_mirror       <= cfg_wdata[0];
				pcp_pkg::REG_TRUECOLOR:    cfg_q.truecolor_visual <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[hw/rtl/pcp_pack.sv]
// ----------------------------------------------------------------------------
// pcp_pack
// Gray conversion, channel truncation, bit reversal and packing of one item.
// ----------------------------------------------------------------------------
module pcp_pack #(
	parameter int PALETTE_ENTRIES = 16
) (
	input  pcp_pkg::cfg_t      cfg,
	input  pcp_pkg::in_item_t  item,
	output pcp_pkg::out_item_t result
);

	localparam logic [8:0] IDX_LIMIT = 9'(PALETTE_ENTRIES);

	function automatic logic [7:0] rev8(input logic [7:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) r[i] = v[7-i];
		return r;
	endfunction

	function automatic logic [5:0] rev6(input logic [5:0] v);
		logic [5:0] r;
		for (int i = 0; i < 6; i++) r[i] = v[5-i];
		return r;
	endfunction

	function automatic logic [4:0] rev5(input logic [4:0] v);
		logic [4:0] r;
		for (int i = 0; i < 5; i++) r[i] = v[4-i];
		return r;
	endfunction

	logic [23:0] gray_sum;
	logic [15:0] red, green, blue;
	logic [7:0]  r8, g8, b8;
	logic [4:0]  r5, b5;
	logic [5:0]  g6;
	logic [31:0] word;

	// Weighted gray: (77R + 151G + 28B + 127) >> 8 always fits in 16 bits
	assign gray_sum = 24'(item.red_level) * 24'd77
			+ 24'(item.green_level) * 24'd151
			+ 24'(item.blue_level) * 24'd28
			+ 24'd127;

	assign red   = cfg.grayscale_on ? gray_sum[23:8] : item.red_level;
	assign green = cfg.grayscale_on ? gray_sum[23:8] : item.green_level;
	assign blue  = cfg.grayscale_on ? gray_sum[23:8] : item.blue_level;

	assign r8 = cfg.bit_mirror ? rev8(red[15:8])   : red[15:8];
	assign g8 = cfg.bit_mirror ? rev8(green[15:8]) : green[15:8];
	assign b8 = cfg.bit_mirror ? rev8(blue[15:8])  : blue[15:8];
	assign r5 = cfg.bit_mirror ? rev5(red[15:11])  : red[15:11];
	assign g6 = cfg.bit_mirror ? rev6(green[15:10]) : green[15:10];
	assign b5 = cfg.bit_mirror ? rev5(blue[15:11]) : blue[15:11];

	// Unused format code 3 falls into the 16-bit layout
	always_comb begin
		case (cfg.color_layout)
			pcp_pkg::FMT_ARGB8888: word = {8'd0, r8, g8, b8};
			pcp_pkg::FMT_RGBA8888: word = {r8, g8, b8, 8'd0};
			default:               word = {16'd0, r5, g6, b5};
		endcase
	end

	always_comb begin
		result.entry_out    = 4'd0;
		result.packed_color = 32'd0;
		if (!cfg.truecolor_visual) begin
			result.status = pcp_pkg::ST_NOTTRUE;
		end else if ({1'b0, item.entry_index} >= IDX_LIMIT) begin
			result.status = pcp_pkg::ST_RANGE;
		end else begin
			result.status       = pcp_pkg::ST_OK;
			result.entry_out    = item.entry_index[3:0];
			result.packed_color = word;
		end
	end

endmodule

[hw/rtl/palette_color_packer_unit.sv]
// ----------------------------------------------------------------------------
// palette_color_packer_unit
// Converts a palette request into a packed pixel word with a status code.
//
// Channel  Dir  Bits        Contents
// s_axis   in   tdata 56    entry_index, red_level, green_level, blue_level
// m_axis   out  tdata 40    entry_out, packed_color; tuser 2: status
// cfg      in   2-bit data  color_layout, grayscale_on, bit_mirror, truecolor
//
// One item per cycle while m_tready keeps the output moving; each item passes
// the input register, then the result register after the gray/pack logic.
// The arst_n reset empties both stages and loads the register defaults.
// A stalled output holds its item; the input stage keeps accepting as long
// as either stage has room, so ready drops only when both are full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module palette_color_packer_unit #(
	parameter int PALETTE_ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [1:0]  cfg_wdata,
	// Input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	// [7:0] entry_index, [23:8] red_level, [39:24] green_level, [55:40] blue_level
	input  logic [55:0] s_tdata,
	// Output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// [3:0] entry_out, [35:4] packed_color, [39:36] zero
	output logic [39:0] m_tdata,
	// [1:0] status
	output logic [1:0]  m_tuser
);

	pcp_pkg::cfg_t      cfg;
	pcp_pkg::in_item_t  item_s1;
	pcp_pkg::out_item_t result;
	pcp_pkg::out_item_t result_s2;
	logic               valid_s1;
	logic               valid_s2;
	logic               load_s2;
	logic               accept;

	pcp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	pcp_pack #(
		.PALETTE_ENTRIES (PALETTE_ENTRIES)
	) u_pack (
		.cfg    (cfg),
		.item   (item_s1),
		.result (result)
	);

	assign load_s2  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || !valid_s2 || m_tready;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (load_s2) begin
				valid_s1 <= 1'b0;
			end
			if (load_s2) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.entry_index <= s_tdata[7:0];
			item_s1.red_level   <= s_tdata[23:8];
			item_s1.green_level <= s_tdata[39:24];
			item_s1.blue_level  <= s_tdata[55:40];
		end
		if (load_s2) begin
			result_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'd0, result_s2.packed_color, result_s2.entry_out};
	assign m_tuser  = result_s2.status;

	// A new result appears only when the input stage held an item
	`ASSERT_CLK(a_out_from_s1, $rose(valid_s2) |-> $past(valid_s1), "result without item")
	// A held input item is never dropped
	`ASSERT_CLK(a_s1_hold, (valid_s1 && !load_s2) |=> valid_s1, "input item lost")
	// Error results carry no word and no entry
	`ASSERT_CLK(a_err_zero,
		(valid_s2 && result_s2.status != pcp_pkg::ST_OK) |->
		(result_s2.packed_color == 32'd0 && result_s2.entry_out == 4'd0),
		"error result not cleared")
	// Status codes above not-truecolor have no meaning
	`ASSERT_NEVER(a_status_code, valid_s2 && result_s2.status > pcp_pkg::ST_NOTTRUE, "bad status")

endmodule

[verif/pcp_checker.sv]
// ----------------------------------------------------------------------------
// pcp_checker
// Watches the configuration port and both streams of the palette color
// packer. It keeps its own copy of the registers and predicts the entry,
// the packed word and the status of every item taken in. Each item that
// leaves the block is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module pcp_checker #(
	parameter int PALETTE_ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [1:0]  cfg_wdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [55:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,
	input  logic [1:0]  m_tuser,
	output int          mismatch_count,
	output int          outstanding
);

	pcp_pkg::cfg_t      cfg_copy;
	pcp_pkg::out_item_t pending_pixels[$];

	// Keep the top bits of a 16-bit level, optionally mirrored
	function automatic logic [31:0] channel_bits(logic [15:0] level, int unsigned width,
			logic rev);
		logic [15:0] top;
		logic [15:0] flip;
		top = level >> (16 - width);
		flip = '0;
		for (int i = 0; i < width; i++)
			flip[width - 1 - i] = top[i];
		return rev ? 32'(flip) : 32'(top);
	endfunction

	function automatic pcp_pkg::out_item_t pack_pixel(pcp_pkg::cfg_t cfg,
			pcp_pkg::in_item_t req);
		pcp_pkg::out_item_t res;
		logic [31:0]        gray;
		logic [15:0]        r;
		logic [15:0]        g;
		logic [15:0]        b;
		logic               rev;
		r = req.red_level;
		g = req.green_level;
		b = req.blue_level;
		rev = cfg.bit_mirror;
		if (cfg.grayscale_on) begin
			gray = (32'(r) * 77 + 32'(g) * 151 + 32'(b) * 28 + 127) >> 8;
			r = gray[15:0];
			g = gray[15:0];
			b = gray[15:0];
		end
		res = '0;
		// the visual check wins over the index check
		if (!cfg.truecolor_visual) begin
			res.status = pcp_pkg::ST_NOTTRUE;
		end else if (int'(req.entry_index) >= PALETTE_ENTRIES) begin
			res.status = pcp_pkg::ST_RANGE;
		end else begin
			res.status = pcp_pkg::ST_OK;
			res.entry_out = req.entry_index[3:0];
			// bit 1 alone picks the 16-bit layout, so the unused code packs as RGB565
			if (cfg.color_layout[1])
				res.packed_color = (channel_bits(r, 5, rev) << 11)
					| (channel_bits(g, 6, rev) << 5) | channel_bits(b, 5, rev);
			else if (cfg.color_layout == pcp_pkg::FMT_RGBA8888)
				res.packed_color = (channel_bits(r, 8, rev) << 24)
					| (channel_bits(g, 8, rev) << 16) | (channel_bits(b, 8, rev) << 8);
			else
				res.packed_color = (channel_bits(r, 8, rev) << 16)
					| (channel_bits(g, 8, rev) << 8) | channel_bits(b, 8, rev);
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pcp_pkg::in_item_t  req;
		pcp_pkg::out_item_t got;
		pcp_pkg::out_item_t want;
		int                 bad;
		bad = 0;
		if (!arst_n) begin
			cfg_copy <= '{color_layout: pcp_pkg::FMT_ARGB8888, grayscale_on: 1'b0,
				bit_mirror: 1'b0, truecolor_visual: 1'b1};
			pending_pixels.delete();
			outstanding <= 0;
			mismatch_count <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					pcp_pkg::REG_COLOR_LAYOUT: cfg_copy.color_layout <= cfg_wdata;
					pcp_pkg::REG_GRAYSCALE_ON: cfg_copy.grayscale_on <= cfg_wdata[0];
					pcp_pkg::REG_BIT_MIRROR:   cfg_copy.bit_mirror <= cfg_wdata[0];
					pcp_pkg::REG_TRUECOLOR:    cfg_copy.truecolor_visual <= cfg_wdata[0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got.entry_out = m_tdata[3:0];
				got.packed_color = m_tdata[35:4];
				got.status = m_tuser;
				if (pending_pixels.size() == 0) begin
					$display("%0t: unexpected item entry %h color %h status %h",
						$time, got.entry_out, got.packed_color, got.status);
					bad++;
				end else begin
					want = pending_pixels.pop_front();
					if (got.entry_out !== want.entry_out) begin
						$display("%0t: entry_out expected %h actual %h",
							$time, want.entry_out, got.entry_out);
						bad++;
					end
					if (got.packed_color !== want.packed_color) begin
						$display("%0t: packed_color expected %h actual %h",
							$time, want.packed_color, got.packed_color);
						bad++;
					end
					if (got.status !== want.status) begin
						$display("%0t: status expected %h actual %h",
							$time, want.status, got.status);
						bad++;
					end
					if (m_tdata[39:36] !== 4'h0) begin
						$display("%0t: tdata pad expected 0 actual %h", $time, m_tdata[39:36]);
						bad++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				req.entry_index = s_tdata[7:0];
				req.red_level = s_tdata[23:8];
				req.green_level = s_tdata[39:24];
				req.blue_level = s_tdata[55:40];
				pending_pixels.push_back(pack_pixel(cfg_copy, req));
			end
			outstanding <= pending_pixels.size();
			mismatch_count <= mismatch_count + bad;
		end
	end

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Regression bench of the palette color packer. Drives directed corner
// items, then sweeps every register setting with random items, bursty input
// and a stalling output. The checker predicts and compares every item.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int         PALETTE_ENTRIES  = 16;
	localparam int         CYCLE_LIMIT      = 400000;
	localparam int         RANDOM_PER_PHASE = 42;
	localparam logic [1:0] FMT_UNUSED       = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [1:0]  cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;
	int          mismatch_count;
	int          outstanding;
	int          burst_left;
	int          gap_max;
	int          cycle_count;

	palette_color_packer_unit #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	pcp_checker #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.mismatch_count(mismatch_count), .outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic push_request(input logic [7:0] idx, input logic [15:0] r,
			input logic [15:0] g, input logic [15:0] b);
		// open a new burst behind a random gap
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			repeat ($urandom_range(0, gap_max)) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
			end
		end
		burst_left--;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {b, g, r, idx};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Drop valid and wait until every item has come out
	task automatic drain;
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_level();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hffff;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [7:0] rand_index();
		if ($urandom_range(0, 9) < 7)
			return 8'($urandom_range(0, PALETTE_ENTRIES - 1));
		return 8'($urandom_range(0, 255));
	endfunction

	// Output back-pressure: switch between stall patterns at random spans
	initial begin
		int mode;
		int span;
		m_tready = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(16, 160);
			for (int k = 0; k < span; k++) begin
				@(negedge clk);
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= (k % 4 == 0);
					default: m_tready <= (k % 16 >= 10);
				endcase
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("palette_color_packer_unit regression: fail");
		$finish;
	end

	initial begin
		int combo;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = pcp_pkg::REG_COLOR_LAYOUT;
		cfg_wdata = 2'd0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		burst_left = 0;
		gap_max = 3;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset defaults: ARGB8888, truecolor
		push_request(8'd0, 16'h0000, 16'h0000, 16'h0000);
		push_request(8'd15, 16'hffff, 16'hffff, 16'hffff);
		push_request(8'd16, 16'h1234, 16'h5678, 16'h9abc);
		push_request(8'd255, 16'hffff, 16'hffff, 16'hffff);
		push_request(8'd1, 16'h8000, 16'h0001, 16'hffff);
		push_request(8'd7, 16'haaaa, 16'h5555, 16'haaaa);
		push_request(8'd8, 16'h5555, 16'haaaa, 16'h5555);
		push_request(8'd3, 16'h0800, 16'h0400, 16'h0100);
		drain;

		// unused format code, gray and mirrored bits
		write_reg(pcp_pkg::REG_COLOR_LAYOUT, FMT_UNUSED);
		write_reg(pcp_pkg::REG_GRAYSCALE_ON, 2'd1);
		write_reg(pcp_pkg::REG_BIT_MIRROR, 2'd1);
		push_request(8'd15, 16'hffff, 16'hffff, 16'hffff);
		push_request(8'd2, 16'h1234, 16'habcd, 16'h0f0f);
		push_request(8'd20, 16'hffff, 16'h0000, 16'hffff);
		drain;

		// not truecolor overrides any index
		write_reg(pcp_pkg::REG_TRUECOLOR, 2'd0);
		push_request(8'd255, 16'hffff, 16'hffff, 16'hffff);
		push_request(8'd0, 16'h1234, 16'h5678, 16'h9abc);
		drain;

		// visit every register setting in a scrambled order
		for (int c = 0; c < 32; c++) begin
			combo = (c * 13 + 5) % 32;
			write_reg(pcp_pkg::REG_COLOR_LAYOUT, 2'(combo % 4));
			write_reg(pcp_pkg::REG_GRAYSCALE_ON, 2'((combo / 4) % 2));
			write_reg(pcp_pkg::REG_BIT_MIRROR, 2'((combo / 8) % 2));
			write_reg(pcp_pkg::REG_TRUECOLOR, 2'(1 - (combo / 16)));
			gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = 0;
			repeat (RANDOM_PER_PHASE)
				push_request(rand_index(), rand_level(), rand_level(), rand_level());
			drain;
		end

		if (mismatch_count == 0 && outstanding == 0)
			$display("palette_color_packer_unit regression: pass");
		else
			$display("palette_color_packer_unit regression: fail");
		$finish;
	end

endmodule

[palette_color_packer_unit.f]
+incdir+hw/rtl
hw/rtl/pcp_pkg.sv
hw/rtl/pcp_cfg_regs.sv
hw/rtl/pcp_pack.sv
hw/rtl/palette_color_packer_unit.sv
verif/pcp_checker.sv
verif/tb_top.sv
